>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/aip_pkg.sv
package aip_pkg;

  // Character codes the classifier looks for.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  // Digit values and bases.
  localparam int unsigned DIGIT_W    = 6;
  localparam logic [DIGIT_W-1:0] DIGIT_BAD  = 6'd63;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE = 3'd3;
  localparam logic [2:0] ST_BAD_BASE = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic REG_TARGET_TYPE = 1'b0;
  localparam logic REG_BASE_MODE   = 1'b1;
  localparam logic [4:0] TARGET_TYPE_RESET = 5'd5;
  localparam logic [5:0] BASE_MODE_RESET   = 6'd0;

  // Queue between the classifier and the parser.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified character.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_minus;
    logic               is_nul;
    logic               is_zero;
    logic               is_x;
    logic               start_new;
  } char_class_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/aip_front.sv
module aip_front import aip_pkg::*; (
  input  logic [7:0]    char_code,
  input  logic          start_new,
  input  logic          in_valid,
  input  queue_status_t q_stat,
  output logic          in_stall,
  output logic          push,
  output char_class_t   entry
);

  logic [7:0] upper;

  // Take a beat whenever the queue has room.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Fold lower case onto upper case before the letter test.
  always_comb begin
    if (char_code inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      upper = char_code - CASE_SHIFT;
    end else begin
      upper = char_code;
    end
  end

  // Digit value and the special characters the parser reacts to.
  always_comb begin
    entry.start_new = start_new;
    entry.is_minus  = (char_code == CH_MINUS);
    entry.is_nul    = (char_code == CH_NUL);
    entry.is_zero   = (char_code == CH_ZERO);
    entry.is_x      = (upper == CH_UPPER_X);
    if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      entry.digit = DIGIT_W'(char_code - CH_ZERO);
    end else if (upper inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      entry.digit = DIGIT_W'(upper - CH_UPPER_A) + DIGIT_TEN;
    end else begin
      entry.digit = DIGIT_BAD;
    end
  end

endmodule

>>> rtl/aip_queue.sv
module aip_queue import aip_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  char_class_t   push_entry,
  input  logic          pop,
  output char_class_t   head,
  output queue_status_t q_stat
);

  char_class_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/aip_back.sv
module aip_back import aip_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [5:0]    cfg_data,
  input  char_class_t   head,
  input  queue_status_t q_stat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   value,
  output logic [2:0]    status,
  output logic [15:0]   chars_consumed
);

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_PREFIX = 5'b00010,
    PH_SIGN   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } result_t;

  logic [4:0]  target_type;
  logic [5:0]  base_mode;

  phase_t      phase, phase_next, ph;
  logic [63:0] acc, acc_e, acc_next;
  logic        neg, neg_e, neg_next;
  logic [5:0]  base, base_e, base_next;
  logic [15:0] cnt, cnt_e, cnt_next;

  logic        emit, go_sign, go_digits, count_inc;
  result_t     em;
  result_t     fin;

  // Truncate the signed image to the target type and range-check it.
  function automatic result_t finish(input logic [63:0] a, input logic n,
                                     input logic [4:0] t);
    logic [63:0] v;
    logic [63:0] mask;
    logic [63:0] ext;
    logic        sgn;
    logic        narrow;
    logic        msb;
    result_t     r;
    v      = n ? (64'd0 - a) : a;
    mask   = '1;
    msb    = 1'b0;
    narrow = 1'b1;
    sgn    = (t inside {5'd0, 5'd2, 5'd4, 5'd5});
    case (t)
      5'd0, 5'd1: begin mask = 64'h0000_0000_0000_00FF; msb = v[7];  end
      5'd2, 5'd3: begin mask = 64'h0000_0000_0000_FFFF; msb = v[15]; end
      5'd4, 5'd6: begin mask = 64'h0000_0000_00FF_FFFF; msb = v[23]; end
      5'd5, 5'd7: begin mask = 64'h0000_0000_FFFF_FFFF; msb = v[31]; end
      5'd8, 5'd12: begin mask = 64'h0000_00FF_FFFF_FFFF; narrow = 1'b0; end
      5'd9, 5'd13: begin mask = 64'h0000_FFFF_FFFF_FFFF; narrow = 1'b0; end
      5'd10, 5'd14: begin mask = 64'h00FF_FFFF_FFFF_FFFF; narrow = 1'b0; end
      default: begin mask = '1; narrow = 1'b0; end
    endcase
    ext      = (v & mask) | (msb ? ~mask : 64'd0);
    r.value  = v & mask;
    r.status = ST_OK;
    if (t > 5'd15) begin
      r.value  = '0;
      r.status = ST_BAD_TYPE;
    end else if (narrow && (sgn ? (ext != v) : ((v & ~mask) != 64'd0))) begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= TARGET_TYPE_RESET;
      base_mode   <= BASE_MODE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_TYPE: target_type <= cfg_data[4:0];
        REG_BASE_MODE:   base_mode   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take the queue head whenever the result register can take a beat.
  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  // A start flag clears the parse before the character is looked at.
  always_comb begin
    if (head.start_new) begin
      ph = PH_SKIP; acc_e = '0; neg_e = 1'b0; base_e = '0; cnt_e = '0;
    end else begin
      ph = phase; acc_e = acc; neg_e = neg; base_e = base; cnt_e = cnt;
    end
  end

  // Truncated and range-checked form of the number as it stands.
  assign fin = finish(acc_e, neg_e, target_type);

  // One character of the parse; phases fall through within the beat.
  always_comb begin
    phase_next = ph;
    acc_next   = acc_e;
    neg_next   = neg_e;
    base_next  = base_e;
    emit       = 1'b0;
    em.value   = '0;
    em.status  = ST_OK;
    go_sign    = 1'b0;
    go_digits  = 1'b0;
    count_inc  = 1'b0;
    case (ph)
      PH_SKIP: begin
        if (!head.is_minus && head.digit == DIGIT_BAD) begin
          if (head.is_nul) begin
            emit      = 1'b1;
            em.status = ST_EMPTY;
          end else begin
            count_inc = 1'b1;
          end
        end else if (base_mode == BASE_AUTO) begin
          if (head.is_zero) begin
            count_inc  = 1'b1;
            phase_next = PH_PREFIX;
          end else begin
            base_next = BASE_DEC;
            go_sign   = 1'b1;
          end
        end else if (base_mode < BASE_MIN || base_mode > BASE_MAX) begin
          emit      = 1'b1;
          em.status = ST_BAD_BASE;
        end else begin
          base_next = base_mode;
          go_sign   = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (head.is_x) begin
          base_next  = BASE_HEX;
          count_inc  = 1'b1;
          phase_next = PH_SIGN;
        end else begin
          base_next = BASE_OCT;
          go_sign   = 1'b1;
        end
      end
      PH_SIGN:   go_sign   = 1'b1;
      PH_DIGITS: go_digits = 1'b1;
      default: ;
    endcase
    // Optional minus sign after the prefix.
    if (go_sign) begin
      phase_next = PH_DIGITS;
      if (head.is_minus) begin
        neg_next  = 1'b1;
        count_inc = 1'b1;
      end else begin
        go_digits = 1'b1;
      end
    end
    // Accumulate a digit, or end the number on anything else.
    if (go_digits) begin
      if (head.digit < base_next) begin
        // The wrapped multiply-add; the base is at most six bits wide.
        acc_next  = acc_e * {58'd0, base_next} + {58'd0, head.digit};
        count_inc = 1'b1;
      end else begin
        emit = 1'b1;
        em   = fin;
      end
    end
    if (emit) begin
      phase_next = PH_DONE;
    end
    if (count_inc && cnt_e != 16'hFFFF) begin
      cnt_next = cnt_e + 16'd1;
    end else begin
      cnt_next = cnt_e;
    end
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
      acc   <= '0;
      neg   <= 1'b0;
      base  <= '0;
      cnt   <= '0;
    end else if (pop) begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      base  <= base_next;
      cnt   <= cnt_next;
    end
  end

  // Result register; it reloads in the cycle its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      value          <= em.value;
      status         <= em.status;
      chars_consumed <= cnt_e;
    end
  end

endmodule

>>> rtl/ascii_integer_parser.sv
// An accepted character waits in the four-entry queue; the result that it ends
// is registered in the result register once the parser takes it from the queue.
// Throughput: one character per cycle, set by the 64-bit by 6-bit multiply-add of
// the parser, while out_stall holds no result; input stalls only on a full queue.
// Reset (synchronous, active high) empties the queue, drops any result, clears
// the parse state and loads target_type 5 and base_mode 0 (automatic).
`include "assert_macros.svh"

module ascii_integer_parser import aip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        start_new,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic [2:0]  status,
  output logic [15:0] chars_consumed
);

  logic          push;
  logic          pop;
  char_class_t   entry;
  char_class_t   head;
  queue_status_t q_stat;

  // Classifier.
  aip_front u_front (
    .char_code (char_code),
    .start_new (start_new),
    .in_valid  (in_valid),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .push      (push),
    .entry     (entry)
  );

  // Queue between classifier and parser.
  aip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Parser and result register.
  aip_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .status         (status),
    .chars_consumed (chars_consumed)
  );

  // The parser never reads an empty queue.
  `ASSERT_IMPLIES(a_pop_not_empty, pop, !q_stat.empty, "pop from an empty queue")
  // With the result register free, a waiting character is always taken.
  `ASSERT_IMPLIES(a_queue_drains, !q_stat.empty && !out_valid, pop, "parser idles with work queued")
  // Error results other than a range error carry a zero value.
  `ASSERT_IMPLIES(a_error_value_zero,
    out_valid && (status == ST_EMPTY || status == ST_BAD_TYPE || status == ST_BAD_BASE),
    value == 64'd0, "error result with a non-zero value")

endmodule
